// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/jpss_pkg.sv =====
// Shared types and constants for the JSON path segment scanner.
package jpss_pkg;

  localparam int INDEX_BITS = 32;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [INDEX_BITS+3:0] index_wide_t;

  localparam logic [3:0] ERR_NONE          = 4'd0;
  localparam logic [3:0] ERR_DOT_AT_END    = 4'd1;
  localparam logic [3:0] ERR_BAD_AFTER_DOT = 4'd2;
  localparam logic [3:0] ERR_OPEN_QUOTE    = 4'd3;
  localparam logic [3:0] ERR_EMPTY_QUOTE   = 4'd4;
  localparam logic [3:0] ERR_BRACKET_END   = 4'd5;
  localparam logic [3:0] ERR_NOT_DIGIT     = 4'd6;
  localparam logic [3:0] ERR_OVERFLOW      = 4'd7;
  localparam logic [3:0] ERR_NO_CLOSE      = 4'd8;
  localparam logic [3:0] ERR_LEADING_ZERO  = 4'd9;
  localparam logic [3:0] ERR_BAD_START     = 4'd10;

  typedef struct packed {
    logic [7:0] path_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic        key_byte_valid;
    logic [7:0]  key_byte;
    logic        segment_end;
    logic        segment_kind;
    logic [31:0] index_value;
    logic [15:0] segment_count;
    logic        error_flag;
    logic [3:0]  error_code;
    logic        path_done;
    logic        path_ok;
  } out_beat_t;

  // Control from the pipeline to the scanner for one character.
  typedef struct packed {
    logic     step;
    in_beat_t beat;
  } scan_req_t;

endpackage

// ===== hdl/jpss_scan.sv =====
// Path parsing state machine: one character per step, result computed combinationally.
`include "assert_macros.svh"

module jpss_scan
  import jpss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  scan_req_t req,
  output out_beat_t result
);

  typedef enum logic [3:0] {
    PH_START,
    PH_DOT,
    PH_KEY,
    PH_QFIRST,
    PH_QUOTE,
    PH_BRACKET,
    PH_INDEX
  } phase_t;

  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [15:0] SEG_MAX   = 16'hFFFF;

  phase_t      phase, phase_next;
  index_t      acc, acc_next;
  logic [15:0] seg, seg_next;
  logic [3:0]  err, err_next;

  logic [7:0]  c;
  logic        last;
  logic        is_alpha, is_digit, is_key_char;
  logic [3:0]  digit;
  index_wide_t acc_times_ten;
  logic        kv, se, kind;
  logic [31:0] iv;

  assign c    = req.beat.path_byte;
  assign last = req.beat.last_byte;

  assign is_alpha    = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_key_char = is_alpha || is_digit || c == CH_UNDER || c == CH_MINUS;
  assign digit       = 4'(c - CH_ZERO);

  // acc*10 + digit, four spare bits catch overflow past INDEX_BITS.
  assign acc_times_ten = (index_wide_t'(acc) << 3) + (index_wide_t'(acc) << 1)
                         + index_wide_t'(digit);

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    err_next   = err;
    kv         = 1'b0;
    se         = 1'b0;
    kind       = 1'b0;
    iv         = '0;

    if (err == ERR_NONE) begin
      case (phase)
        PH_KEY: begin
          if (is_key_char) begin
            kv = 1'b1;
          end else begin
            se = 1'b1;
            // A terminating dot or bracket opens the next segment; any other character is an error.
            if (c == CH_DOT) begin
              phase_next = PH_DOT;
            end else if (c == CH_LBRACK) begin
              phase_next = PH_BRACKET;
            end else begin
              phase_next = PH_START;
              err_next   = ERR_BAD_START;
            end
          end
        end
        PH_DOT: begin
          if (c == CH_QUOTE) begin
            phase_next = PH_QFIRST;
          end else if (is_alpha || c == CH_UNDER) begin
            kv         = 1'b1;
            phase_next = PH_KEY;
          end else begin
            err_next = ERR_BAD_AFTER_DOT;
          end
        end
        PH_QFIRST: begin
          if (c == CH_QUOTE) begin
            err_next = ERR_EMPTY_QUOTE;
          end else begin
            kv         = 1'b1;
            phase_next = PH_QUOTE;
          end
        end
        PH_QUOTE: begin
          if (c == CH_QUOTE) begin
            se         = 1'b1;
            phase_next = PH_START;
          end else begin
            kv = 1'b1;
          end
        end
        PH_BRACKET: begin
          if (is_digit) begin
            acc_next   = index_t'(digit);
            phase_next = PH_INDEX;
          end else begin
            err_next = ERR_NOT_DIGIT;
          end
        end
        PH_INDEX: begin
          if (is_digit) begin
            if (acc == '0) begin
              err_next = ERR_LEADING_ZERO;
            end else if (acc_times_ten[INDEX_BITS+3:INDEX_BITS] != 4'd0) begin
              err_next = ERR_OVERFLOW;
            end else begin
              acc_next = acc_times_ten[INDEX_BITS-1:0];
            end
          end else if (c == CH_RBRACK) begin
            se         = 1'b1;
            kind       = 1'b1;
            iv         = 32'(acc);
            acc_next   = '0;
            phase_next = PH_START;
          end else begin
            err_next = ERR_NO_CLOSE;
          end
        end
        default: begin
          if (c == CH_DOT) begin
            phase_next = PH_DOT;
          end else if (c == CH_LBRACK) begin
            phase_next = PH_BRACKET;
          end else begin
            phase_next = PH_START;
            err_next   = ERR_BAD_START;
          end
        end
      endcase

      // The final character closes a pending bare key or flags an open segment.
      if (last && err_next == ERR_NONE) begin
        case (phase_next)
          PH_KEY:     se       = 1'b1;
          PH_DOT:     err_next = ERR_DOT_AT_END;
          PH_QFIRST:  err_next = ERR_OPEN_QUOTE;
          PH_QUOTE:   err_next = ERR_OPEN_QUOTE;
          PH_BRACKET: err_next = ERR_BRACKET_END;
          PH_INDEX:   err_next = ERR_NO_CLOSE;
          default:    err_next = ERR_NONE;
        endcase
      end
    end

    seg_next = (se && seg != SEG_MAX) ? seg + 16'd1 : seg;

    result.key_byte_valid = kv;
    result.key_byte       = kv ? c : 8'd0;
    result.segment_end    = se;
    result.segment_kind   = kind;
    result.index_value    = iv;
    result.segment_count  = seg_next;
    result.error_flag     = (err_next != ERR_NONE);
    result.error_code     = err_next;
    result.path_done      = last;
    result.path_ok        = last && err_next == ERR_NONE && seg_next != 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      acc   <= '0;
      seg   <= '0;
      err   <= ERR_NONE;
    end else if (req.step) begin
      if (last) begin
        phase <= PH_START;
        acc   <= '0;
        seg   <= '0;
        err   <= ERR_NONE;
      end else begin
        phase <= phase_next;
        acc   <= acc_next;
        seg   <= seg_next;
        err   <= err_next;
      end
    end
  end

  `ASSERT_CLK(a_restart_after_last, clk, rst, req.step && last |=> phase == PH_START && acc == '0 && seg == 16'd0 && err == ERR_NONE, "scanner state not cleared after final character")
  `ASSERT_CLK(a_error_sticky, clk, rst, req.step && !last && err != ERR_NONE |=> err == $past(err) && seg == $past(seg), "held error or count changed after an error")
  `ASSERT_CLK(a_count_monotonic, clk, rst, req.step && !last |=> seg >= $past(seg), "segment count went down within a path")

endmodule

// ===== hdl/json_path_segment_scanner_core.sv =====
// Top level: input register, path scanner and result register with valid/ready handshakes.
// A beat accepted into the input register passes through the scanner into the result register, out_beat.
// Throughput: one beat per cycle while results are taken; the scanner state updates once per character.
// A waiting result holds the scanner, and the input register then takes one beat if empty.
// Reset (rst, synchronous, active high) empties both stages and returns the scanner
// to the start of a path with no segments and no error.
`include "assert_macros.svh"

module json_path_segment_scanner_core
  import jpss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  logic      held_valid;
  in_beat_t  held_beat;
  logic      advance;
  scan_req_t req;
  out_beat_t scan_result;

  // A held character moves into the result register whenever that register can take it.
  assign advance  = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || advance;

  assign req.step = advance;
  assign req.beat = held_beat;

  jpss_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .result (scan_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        held_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_beat <= in_beat;
    end
    if (advance) begin
      out_beat <= scan_result;
    end
  end

  `ASSERT_CLK_ALWAYS(a_reset_empties, clk, rst |=> !out_valid && !held_valid, "pipeline not empty after reset")
  `ASSERT_CLK(a_advance_fills_output, clk, rst, advance |=> out_valid, "result register empty after a character advanced")
  `ASSERT_CLK(a_empty_stage_ready, clk, rst, !held_valid |-> in_ready, "input stage empty but not ready")

endmodule
